[hw/rtl/rcsm_pkg.sv]
// Shared types and constants for the small-modulus Rabin cipher.
package rcsm_pkg;

    localparam int MOD_WIDTH_DEF = 16;
    localparam int PRIME_W       = 15;
    localparam int VALUE_W       = 16;
    localparam int BYTE_W        = 8;
    localparam int COEF_W        = 17;
    localparam int EXP_W         = PRIME_W - 1;
    localparam int ROOT_N        = 4;

    localparam logic [PRIME_W-1:0] PRIME_P_RST = 15'd19;
    localparam logic [PRIME_W-1:0] PRIME_Q_RST = 15'd23;

    // Configuration register indexes.
    localparam logic CFG_PRIME_P = 1'b0;
    localparam logic CFG_PRIME_Q = 1'b1;

    // Command codes.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Operation of the serial modular unit.
    typedef enum logic {
        MU_MUL,
        MU_RED
    } mu_mode_t;

    typedef struct packed {
        logic     start;
        mu_mode_t mode;
    } mu_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ENC_RED,
        S_ENC_MUL,
        S_POW_BASE,
        S_POW_CHK,
        S_POW_MUL,
        S_POW_SQR,
        S_EU_CHK,
        S_EU_DIV,
        S_EU_UPD,
        S_CRT,
        S_ROOTS,
        S_EMIT
    } state_t;

    // Steps of the remainder-theorem recombination.
    typedef enum logic [3:0] {
        CRT_ABS_P,
        CRT_RED_P,
        CRT_MUL_P,
        CRT_ABS_Q,
        CRT_RED_Q,
        CRT_MUL_Q,
        CRT_RED_MQ,
        CRT_MUL_A,
        CRT_RED_MP,
        CRT_MUL_B
    } crt_step_t;

endpackage

[hw/rtl/rcsm_if.sv]
// Stream interfaces for the command and result channels.
interface rcsm_cmd_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [rcsm_pkg::VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

interface rcsm_res_if;
    logic                         valid;
    logic                         ready;
    logic [rcsm_pkg::VALUE_W-1:0] result_value;
    logic                         last;

    modport source (output valid, output result_value, output last, input ready);
    modport sink (input valid, input result_value, input last, output ready);
endinterface

[hw/rtl/rabin_cipher_small_modulus.sv]
// Rabin cipher over n = p*q: byte encryption and four-root decryption.
//
//   channel  dir  beat fields             handshake
//   cmd      in   command, value          valid/ready
//   res      out  result_value, last      valid/ready
//   cfg      in   cfg_index, cfg_data     cfg_we, no back-pressure
//
// Every modular operation runs on one bit-serial unit of width DW,
// DW = max(MOD_WIDTH, 16). Encrypt takes two operations. Decrypt takes per
// prime one reduction plus one or two operations per exponent bit, one per
// Euclid step and ten for recombination.
// Reset clears control and loads primes 19 and 23; there is no clearing pass.
// One command is in flight at a time; a pending result beat does not stop the
// next command from being accepted once the current one has been emitted.
module rabin_cipher_small_modulus #(
    parameter int MOD_WIDTH = rcsm_pkg::MOD_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rcsm_cmd_if.sink                     cmd,
    rcsm_res_if.source                   res,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [rcsm_pkg::PRIME_W-1:0] cfg_data
);

    localparam int DW  = (MOD_WIDTH > rcsm_pkg::VALUE_W) ? MOD_WIDTH : rcsm_pkg::VALUE_W;
    localparam int PW  = rcsm_pkg::PRIME_W;
    localparam int CFW = rcsm_pkg::COEF_W;
    localparam int EW  = rcsm_pkg::EXP_W;
    localparam int RN  = rcsm_pkg::ROOT_N;
    localparam int VW  = rcsm_pkg::VALUE_W;
    localparam int BW  = rcsm_pkg::BYTE_W;
    localparam int PRW = CFW + PW + 1;

    rcsm_pkg::state_t    state_reg, state_next;
    rcsm_pkg::crt_step_t crt_reg, crt_next;

    logic [PW-1:0]        prime_p_reg, prime_q_reg;
    logic [MOD_WIDTH-1:0] n_reg;
    logic [2*PW-1:0]      pq_prod;

    logic                 cmd_reg, cmd_next;
    logic [VW-1:0]        val_reg, val_next;
    logic                 which_reg, which_next;
    logic [EW-1:0]        exp_reg, exp_next;
    logic [DW-1:0]        base_reg, base_next, acc_reg, acc_next;
    logic [PW-1:0]        mp_reg, mp_next, mq_reg, mq_next;
    logic [PW-1:0]        ea_reg, ea_next, eb_reg, eb_next, d_reg, d_next;
    logic signed [CFW-1:0] s0_reg, s0_next, s1_reg, s1_next;
    logic signed [CFW-1:0] t0_reg, t0_next, t1_reg, t1_next;
    logic [DW-1:0]        tmp_reg, tmp_next, tmp2_reg, tmp2_next;
    logic [DW-1:0]        ra_reg, ra_next, rb_reg, rb_next;
    logic [DW-1:0]        root_reg [RN];
    logic [DW-1:0]        root_next [RN];
    logic [RN-1:0]        mask_reg, mask_next;
    logic                 launched_reg, launched_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VW-1:0]        out_value_reg, out_value_next;
    logic                 out_last_reg, out_last_next;

    rcsm_pkg::mu_ctrl_t mu_ctrl;
    logic [DW-1:0]      mu_x, mu_y, mu_m, mu_rem, mu_quo;
    logic               mu_done;

    logic [DW-1:0]   n_ext;
    logic [PW-1:0]   pm;
    logic            op_state, push_ok, push;
    logic [1:0]      idx;
    logic            found;
    logic [RN-1:0]   rest;
    logic [CFW-1:0]  s0_abs, t0_abs;
    logic signed [PRW-1:0] s_diff, t_diff;
    logic [DW:0]     sum, dif;
    logic [DW-1:0]   r0, r1, r2, r3;
    logic [VW-1:0]   bsq;

    assign pq_prod = prime_p_reg * prime_q_reg;
    assign n_ext   = DW'(n_reg);
    assign pm      = which_reg ? prime_q_reg : prime_p_reg;
    assign bsq     = val_reg[BW-1:0] * val_reg[BW-1:0];

    // Configuration registers and the derived modulus.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_p_reg <= rcsm_pkg::PRIME_P_RST;
            prime_q_reg <= rcsm_pkg::PRIME_Q_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcsm_pkg::CFG_PRIME_P: prime_p_reg <= cfg_data;
                rcsm_pkg::CFG_PRIME_Q: prime_q_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= MOD_WIDTH'(pq_prod);
    end

    // Coefficient magnitudes and the Euclid update products.
    always_comb
    begin
        s0_abs = s0_reg[CFW-1] ? CFW'(-s0_reg) : CFW'(s0_reg);
        t0_abs = t0_reg[CFW-1] ? CFW'(-t0_reg) : CFW'(t0_reg);
        s_diff = s0_reg - s1_reg * $signed({1'b0, d_reg});
        t_diff = t0_reg - t1_reg * $signed({1'b0, d_reg});
    end

    // The four roots from the two recombined terms.
    always_comb
    begin
        sum = {1'b0, ra_reg} + {1'b0, rb_reg};
        r0  = (sum >= {1'b0, n_ext}) ? DW'(sum - {1'b0, n_ext}) : sum[DW-1:0];
        dif = (ra_reg >= rb_reg) ? ({1'b0, ra_reg} - {1'b0, rb_reg})
                                 : ({1'b0, ra_reg} + {1'b0, n_ext} - {1'b0, rb_reg});
        r2  = dif[DW-1:0];
        r1  = (r0 == '0) ? '0 : n_ext - r0;
        r3  = (r2 == '0) ? '0 : n_ext - r2;
    end

    // Lowest pending root for the result beat.
    always_comb
    begin
        idx   = '0;
        found = 1'b0;
        for (int i = 0; i < RN; i++)
        begin
            if (mask_reg[i] && !found)
            begin
                idx   = 2'(i);
                found = 1'b1;
            end
        end
        rest = mask_reg & ~(RN'(1) << idx);
    end

    assign push_ok = !out_valid_reg || res.ready;
    assign push    = (state_reg == rcsm_pkg::S_EMIT) && (mask_reg != '0) && push_ok;

    always_comb
    begin
        op_state = state_reg inside {rcsm_pkg::S_ENC_RED, rcsm_pkg::S_ENC_MUL,
                                     rcsm_pkg::S_POW_BASE, rcsm_pkg::S_POW_MUL,
                                     rcsm_pkg::S_POW_SQR, rcsm_pkg::S_EU_DIV,
                                     rcsm_pkg::S_CRT};
    end

    // Request to the serial unit.
    always_comb
    begin
        mu_ctrl.start = op_state && !launched_reg;
        mu_ctrl.mode  = rcsm_pkg::MU_RED;
        mu_x          = '0;
        mu_y          = '0;
        mu_m          = n_ext;
        case (state_reg)
            rcsm_pkg::S_ENC_RED:
            begin
                mu_y = DW'(val_reg[BW-1:0]);
            end
            rcsm_pkg::S_ENC_MUL:
            begin
                mu_ctrl.mode = rcsm_pkg::MU_MUL;
                mu_x         = tmp_reg;
                mu_y         = tmp_reg;
            end
            rcsm_pkg::S_POW_BASE:
            begin
                mu_y = DW'(val_reg);
                mu_m = DW'(pm);
            end
            rcsm_pkg::S_POW_MUL:
            begin
                mu_ctrl.mode = rcsm_pkg::MU_MUL;
                mu_x         = acc_reg;
                mu_y         = base_reg;
                mu_m         = DW'(pm);
            end
            rcsm_pkg::S_POW_SQR:
            begin
                mu_ctrl.mode = rcsm_pkg::MU_MUL;
                mu_x         = base_reg;
                mu_y         = base_reg;
                mu_m         = DW'(pm);
            end
            rcsm_pkg::S_EU_DIV:
            begin
                mu_y = DW'(ea_reg);
                mu_m = DW'(eb_reg);
            end
            rcsm_pkg::S_CRT:
            begin
                case (crt_reg)
                    rcsm_pkg::CRT_ABS_P:  mu_y = DW'(s0_abs);
                    rcsm_pkg::CRT_RED_P:  mu_y = DW'(prime_p_reg);
                    rcsm_pkg::CRT_ABS_Q:  mu_y = DW'(t0_abs);
                    rcsm_pkg::CRT_RED_Q:  mu_y = DW'(prime_q_reg);
                    rcsm_pkg::CRT_RED_MQ: mu_y = DW'(mq_reg);
                    rcsm_pkg::CRT_RED_MP: mu_y = DW'(mp_reg);
                    rcsm_pkg::CRT_MUL_P, rcsm_pkg::CRT_MUL_Q:
                    begin
                        mu_ctrl.mode = rcsm_pkg::MU_MUL;
                        mu_x         = tmp_reg;
                        mu_y         = tmp2_reg;
                    end
                    rcsm_pkg::CRT_MUL_A:
                    begin
                        mu_ctrl.mode = rcsm_pkg::MU_MUL;
                        mu_x         = ra_reg;
                        mu_y         = tmp2_reg;
                    end
                    rcsm_pkg::CRT_MUL_B:
                    begin
                        mu_ctrl.mode = rcsm_pkg::MU_MUL;
                        mu_x         = rb_reg;
                        mu_y         = tmp2_reg;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    rcsm_modunit #(
        .DW (DW)
    ) u_modunit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mu_ctrl),
        .x     (mu_x),
        .y     (mu_y),
        .m     (mu_m),
        .done  (mu_done),
        .rem   (mu_rem),
        .quo   (mu_quo)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcsm_pkg::S_IDLE:
                if (cmd.valid)
                    state_next = rcsm_pkg::S_DISPATCH;
            rcsm_pkg::S_DISPATCH:
                if (cmd_reg == rcsm_pkg::CMD_ENCRYPT)
                    state_next = (n_reg == '0) ? rcsm_pkg::S_EMIT : rcsm_pkg::S_ENC_RED;
                else if (n_reg == '0 || prime_p_reg == '0 || prime_q_reg == '0)
                    state_next = rcsm_pkg::S_IDLE;
                else
                    state_next = rcsm_pkg::S_POW_BASE;
            rcsm_pkg::S_ENC_RED:
                if (mu_done)
                    state_next = rcsm_pkg::S_ENC_MUL;
            rcsm_pkg::S_ENC_MUL:
                if (mu_done)
                    state_next = rcsm_pkg::S_EMIT;
            rcsm_pkg::S_POW_BASE:
                if (mu_done)
                    state_next = rcsm_pkg::S_POW_CHK;
            rcsm_pkg::S_POW_CHK:
                if (exp_reg == '0)
                    state_next = which_reg ? rcsm_pkg::S_EU_CHK : rcsm_pkg::S_POW_BASE;
                else if (exp_reg[0])
                    state_next = rcsm_pkg::S_POW_MUL;
                else
                    state_next = rcsm_pkg::S_POW_SQR;
            rcsm_pkg::S_POW_MUL:
                if (mu_done)
                    state_next = rcsm_pkg::S_POW_SQR;
            rcsm_pkg::S_POW_SQR:
                if (mu_done)
                    state_next = rcsm_pkg::S_POW_CHK;
            rcsm_pkg::S_EU_CHK:
                state_next = (eb_reg == '0) ? rcsm_pkg::S_CRT : rcsm_pkg::S_EU_DIV;
            rcsm_pkg::S_EU_DIV:
                if (mu_done)
                    state_next = rcsm_pkg::S_EU_UPD;
            rcsm_pkg::S_EU_UPD:
                state_next = rcsm_pkg::S_EU_CHK;
            rcsm_pkg::S_CRT:
                if (mu_done && crt_reg == rcsm_pkg::CRT_MUL_B)
                    state_next = rcsm_pkg::S_ROOTS;
            rcsm_pkg::S_ROOTS:
                state_next = rcsm_pkg::S_EMIT;
            rcsm_pkg::S_EMIT:
                if (mask_reg == '0 || (push && rest == '0))
                    state_next = rcsm_pkg::S_IDLE;
            default:
                state_next = rcsm_pkg::S_IDLE;
        endcase
    end

    // Datapath and output updates.
    always_comb
    begin
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        which_next     = which_reg;
        exp_next       = exp_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        mp_next        = mp_reg;
        mq_next        = mq_reg;
        ea_next        = ea_reg;
        eb_next        = eb_reg;
        d_next         = d_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        crt_next       = crt_reg;
        tmp_next       = tmp_reg;
        tmp2_next      = tmp2_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        root_next      = root_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        launched_next  = launched_reg;

        if (mu_done)
            launched_next = 1'b0;
        else if (mu_ctrl.start)
            launched_next = 1'b1;

        case (state_reg)
            rcsm_pkg::S_IDLE:
            begin
                cmd_next = cmd.command;
                val_next = cmd.value;
            end
            rcsm_pkg::S_DISPATCH:
            begin
                // The first exponent always belongs to p, whatever was left behind.
                which_next   = 1'b0;
                exp_next     = EW'(({1'b0, prime_p_reg} + VW'(1)) >> 2);
                acc_next     = (prime_p_reg == PW'(1)) ? '0 : DW'(1);
                mask_next    = RN'(1);
                root_next[0] = DW'(bsq);
            end
            rcsm_pkg::S_ENC_RED:
                if (mu_done)
                    tmp_next = mu_rem;
            rcsm_pkg::S_ENC_MUL:
                if (mu_done)
                    root_next[0] = mu_rem;
            rcsm_pkg::S_POW_BASE:
                if (mu_done)
                    base_next = mu_rem;
            rcsm_pkg::S_POW_CHK:
                if (exp_reg == '0)
                begin
                    if (!which_reg)
                    begin
                        // Root mod p done; set up the exponent for q.
                        mp_next    = acc_reg[PW-1:0];
                        which_next = 1'b1;
                        exp_next   = EW'(({1'b0, prime_q_reg} + VW'(1)) >> 2);
                        acc_next   = (prime_q_reg == PW'(1)) ? '0 : DW'(1);
                    end
                    else
                    begin
                        mq_next  = acc_reg[PW-1:0];
                        ea_next  = prime_p_reg;
                        eb_next  = prime_q_reg;
                        s0_next  = CFW'(1);
                        s1_next  = '0;
                        t0_next  = '0;
                        t1_next  = CFW'(1);
                        crt_next = rcsm_pkg::CRT_ABS_P;
                    end
                end
            rcsm_pkg::S_POW_MUL:
                if (mu_done)
                    acc_next = mu_rem;
            rcsm_pkg::S_POW_SQR:
                if (mu_done)
                begin
                    base_next = mu_rem;
                    exp_next  = exp_reg >> 1;
                end
            rcsm_pkg::S_EU_DIV:
                if (mu_done)
                begin
                    d_next  = mu_quo[PW-1:0];
                    ea_next = eb_reg;
                    eb_next = mu_rem[PW-1:0];
                end
            rcsm_pkg::S_EU_UPD:
            begin
                s0_next = s1_reg;
                s1_next = s_diff[CFW-1:0];
                t0_next = t1_reg;
                t1_next = t_diff[CFW-1:0];
            end
            rcsm_pkg::S_CRT:
                if (mu_done)
                begin
                    case (crt_reg)
                        rcsm_pkg::CRT_ABS_P, rcsm_pkg::CRT_ABS_Q:
                            tmp_next = mu_rem;
                        rcsm_pkg::CRT_RED_P, rcsm_pkg::CRT_RED_Q,
                        rcsm_pkg::CRT_RED_MQ, rcsm_pkg::CRT_RED_MP:
                            tmp2_next = mu_rem;
                        rcsm_pkg::CRT_MUL_P:
                            ra_next = (s0_reg[CFW-1] && mu_rem != '0) ? n_ext - mu_rem : mu_rem;
                        rcsm_pkg::CRT_MUL_Q:
                            rb_next = (t0_reg[CFW-1] && mu_rem != '0) ? n_ext - mu_rem : mu_rem;
                        rcsm_pkg::CRT_MUL_A:
                            ra_next = mu_rem;
                        rcsm_pkg::CRT_MUL_B:
                            rb_next = mu_rem;
                        default: ;
                    endcase
                    crt_next = rcsm_pkg::crt_step_t'(crt_reg + 4'd1);
                end
            rcsm_pkg::S_ROOTS:
            begin
                root_next[0] = r0;
                root_next[1] = r1;
                root_next[2] = r2;
                root_next[3] = r3;
                mask_next    = {r3[DW-1:BW] == '0, r2[DW-1:BW] == '0,
                                r1[DW-1:BW] == '0, r0[DW-1:BW] == '0};
            end
            rcsm_pkg::S_EMIT:
                if (push)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = root_reg[idx][VW-1:0];
                    out_last_next  = (rest == '0);
                    mask_next      = rest;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcsm_pkg::S_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        which_reg     <= which_next;
        exp_reg       <= exp_next;
        base_reg      <= base_next;
        acc_reg       <= acc_next;
        mp_reg        <= mp_next;
        mq_reg        <= mq_next;
        ea_reg        <= ea_next;
        eb_reg        <= eb_next;
        d_reg         <= d_next;
        s0_reg        <= s0_next;
        s1_reg        <= s1_next;
        t0_reg        <= t0_next;
        t1_reg        <= t1_next;
        crt_reg       <= crt_next;
        tmp_reg       <= tmp_next;
        tmp2_reg      <= tmp2_next;
        ra_reg        <= ra_next;
        rb_reg        <= rb_next;
        root_reg      <= root_next;
        mask_reg      <= mask_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign cmd.ready        = (state_reg == rcsm_pkg::S_IDLE);
    assign res.valid        = out_valid_reg;
    assign res.result_value = out_value_reg;
    assign res.last         = out_last_reg;

    a_euclid_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcsm_pkg::S_CRT) |-> (eb_reg == '0))
        else $error("recombination started before Euclid finished");

    a_pow_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcsm_pkg::S_POW_MUL) |-> exp_reg[0])
        else $error("multiply step on a clear exponent bit");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && rest == '0) |=> (state_reg == rcsm_pkg::S_IDLE && out_last_reg))
        else $error("final beat did not return to idle");

    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !launched_reg)
        else $error("command accepted while a modular operation is pending");

endmodule

[hw/rtl/rcsm_modunit.sv]
// Bit-serial modular unit: x*y mod m, or y mod m with quotient, one bit per cycle.
module rcsm_modunit #(
    parameter int DW = rcsm_pkg::MOD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rcsm_pkg::mu_ctrl_t ctrl,
    input  logic [DW-1:0]      x,
    input  logic [DW-1:0]      y,
    input  logic [DW-1:0]      m,
    output logic               done,
    output logic [DW-1:0]      rem,
    output logic [DW-1:0]      quo
);

    localparam int CW = $clog2(DW + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [DW-1:0]      acc_reg, quo_reg, y_reg, x_reg, m_reg;
    rcsm_pkg::mu_mode_t mode_reg;

    logic          ybit;
    logic [DW:0]   t1, t2;
    logic          qb, sub2;
    logic [DW-1:0] s1, s2, addend;

    // One step: double and bring in a dividend bit, reduce, then add x, reduce.
    always_comb
    begin
        ybit   = y_reg[DW-1];
        t1     = {acc_reg, (mode_reg == rcsm_pkg::MU_RED) & ybit};
        qb     = (t1 >= {1'b0, m_reg});
        s1     = qb ? DW'(t1 - {1'b0, m_reg}) : t1[DW-1:0];
        addend = ((mode_reg == rcsm_pkg::MU_MUL) && ybit) ? x_reg : '0;
        t2     = {1'b0, s1} + {1'b0, addend};
        sub2   = (t2 >= {1'b0, m_reg});
        s2     = sub2 ? DW'(t2 - {1'b0, m_reg}) : t2[DW-1:0];
    end

    // Step counter and completion pulse.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and accumulator shift registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            acc_reg  <= '0;
            quo_reg  <= '0;
            y_reg    <= y;
            x_reg    <= x;
            m_reg    <= m;
            mode_reg <= ctrl.mode;
        end
        else if (busy_reg)
        begin
            acc_reg <= s2;
            quo_reg <= {quo_reg[DW-2:0], qb};
            y_reg   <= {y_reg[DW-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = acc_reg;
    assign quo  = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("modular unit restarted while busy");

    a_nonzero_mod: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (m_reg != '0))
        else $error("modular unit running with zero modulus");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (acc_reg < m_reg))
        else $error("modular accumulator not reduced");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !ctrl.start && cnt_reg == CW'(1)) |=> (done_reg && !busy_reg))
        else $error("modular unit missed its completion pulse");

endmodule
